### rtl/stable_priority_queue_top_macros.svh
// Assertion macros for the stable priority queue.
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg)
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/spq_pkg.sv
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PRIO_W = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W  = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic signed [DATA_W-1:0] UNDERFLOW_DATA = -32'sd255;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_FULL      = 2'd2
  } spq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_REM
  } spq_state_t;

  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
  } spq_entry_t;

  typedef struct packed {
    logic             en;
    logic [PTR_W-1:0] addr;
    spq_entry_t       entry;
  } spq_wr_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_W'(DEPTH - 1) : PTR_W'(p - 1'b1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_last(input logic [PTR_W-1:0] head,
                                                input logic [CNT_W-1:0] cnt);
    logic [CNT_W+PTR_W:0] s;
    s = (CNT_W+PTR_W+1)'(head) + (CNT_W+PTR_W+1)'(cnt) - 1'b1;
    if (s >= (CNT_W+PTR_W+1)'(DEPTH)) begin
      s = s - (CNT_W+PTR_W+1)'(DEPTH);
    end
    ptr_last = s[PTR_W-1:0];
  endfunction

endpackage

### rtl/stable_priority_queue_top.sv
// Remove: the head entry is read, then S_REM loads the output register; underflow, full insert and
//   insert into an empty queue load the output register directly on acceptance.
// Insert into a non-empty queue walks back from the tail: S_INS_RD then S_INS_CMP for each entry examined
//   through the single read port of the entry memory, plus S_INS_PUT when the item lands at the front.
// One item in flight; the next item is accepted no earlier than the result's transaction.
// Reset clears count, head, state and output valid; the entry memory is not cleared.
`include "stable_priority_queue_top_macros.svh"

module stable_priority_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // data_in[31:0], priority_in[47:32]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // data_out[31:0], is_empty[32], occupancy[37:33], zero[39:38]
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int PTR_W = spq_pkg::PTR_W;
  localparam int CNT_W = spq_pkg::CNT_W;

  spq_pkg::spq_state_t state_r, state_nxt;
  logic [PTR_W-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [PTR_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    left_r, left_nxt;
  spq_pkg::spq_entry_t item_r;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [spq_pkg::DATA_W-1:0]   out_data_r, out_data_nxt;
  spq_pkg::spq_status_t                out_status_r, out_status_nxt;
  logic                                out_empty_r, out_empty_nxt;
  logic [spq_pkg::OCC_W-1:0]           out_occ_r, out_occ_nxt;

  spq_pkg::spq_wr_t    wr;
  logic [PTR_W-1:0]    rd_addr;
  spq_pkg::spq_entry_t rd_entry;
  spq_pkg::spq_entry_t in_entry;

  logic                              accept;
  logic                              load_out;
  logic signed [spq_pkg::DATA_W-1:0] res_data;
  spq_pkg::spq_status_t              res_status;
  logic [CNT_W-1:0]                  res_count;

  spq_store u_store (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  assign in_entry.prio = in_tdata[47:32];
  assign in_entry.data = in_tdata[31:0];
  assign in_tready = (state_r == spq_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign accept = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    wr.en      = 1'b0;
    wr.addr    = pos_r;
    wr.entry   = item_r;
    rd_addr    = head_r;
    load_out   = 1'b0;
    res_data   = '0;
    res_status = spq_pkg::ST_OK;
    res_count  = count_r;

    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_tuser[0] == spq_pkg::OP_REMOVE) begin
            if (count_r == '0) begin
              load_out   = 1'b1;
              res_data   = spq_pkg::UNDERFLOW_DATA;
              res_status = spq_pkg::ST_UNDERFLOW;
            end else begin
              state_nxt = spq_pkg::S_REM;
            end
          end else if (count_r == CNT_W'(spq_pkg::DEPTH)) begin
            load_out   = 1'b1;
            res_status = spq_pkg::ST_FULL;
          end else if (count_r == '0) begin
            wr.en     = 1'b1;
            wr.addr   = head_r;
            wr.entry  = in_entry;
            res_count = CNT_W'(1);
            count_nxt = res_count;
            load_out  = 1'b1;
          end else begin
            pos_nxt   = spq_pkg::ptr_last(head_r, count_r);
            left_nxt  = count_r;
            state_nxt = spq_pkg::S_INS_RD;
          end
        end
      end
      spq_pkg::S_INS_RD: begin
        rd_addr   = pos_r;
        state_nxt = spq_pkg::S_INS_CMP;
      end
      spq_pkg::S_INS_CMP: begin
        wr.en   = 1'b1;
        wr.addr = spq_pkg::ptr_inc(pos_r);
        if ($signed(rd_entry.prio) > $signed(item_r.prio)) begin
          wr.entry = rd_entry;
          if (left_r == CNT_W'(1)) begin
            state_nxt = spq_pkg::S_INS_PUT;
          end else begin
            pos_nxt   = spq_pkg::ptr_dec(pos_r);
            left_nxt  = CNT_W'(left_r - 1'b1);
            state_nxt = spq_pkg::S_INS_RD;
          end
        end else begin
          res_count = CNT_W'(count_r + 1'b1);
          count_nxt = res_count;
          load_out  = 1'b1;
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      spq_pkg::S_INS_PUT: begin
        wr.en     = 1'b1;
        wr.addr   = pos_r;
        res_count = CNT_W'(count_r + 1'b1);
        count_nxt = res_count;
        load_out  = 1'b1;
        state_nxt = spq_pkg::S_IDLE;
      end
      spq_pkg::S_REM: begin
        res_data  = rd_entry.data;
        res_count = CNT_W'(count_r - 1'b1);
        count_nxt = res_count;
        head_nxt  = spq_pkg::ptr_inc(head_r);
        load_out  = 1'b1;
        state_nxt = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_empty_nxt  = out_empty_r;
    out_occ_nxt    = out_occ_r;
    if (load_out) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = res_data;
      out_status_nxt = res_status;
      out_empty_nxt  = (res_count == '0);
      out_occ_nxt    = spq_pkg::OCC_W'(res_count);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    left_r       <= left_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_empty_r  <= out_empty_nxt;
    out_occ_r    <= out_occ_nxt;
    if (accept) begin
      item_r <= in_entry;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_occ_r, out_empty_r, out_data_r};
  assign out_tuser  = out_status_r;

  `SPQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(spq_pkg::DEPTH),
                  "entry count above depth")
  `SPQ_ASSERT_IMP(a_busy_out_free, state_r != spq_pkg::S_IDLE, !out_valid_r,
                  "result held while busy")
  `SPQ_ASSERT_NXT(a_underflow,
                  accept && in_tuser[0] == spq_pkg::OP_REMOVE && count_r == '0,
                  out_valid_r && out_status_r == spq_pkg::ST_UNDERFLOW,
                  "missing underflow")
  `SPQ_ASSERT_NXT(a_full,
                  accept && in_tuser[0] == spq_pkg::OP_INSERT &&
                  count_r == CNT_W'(spq_pkg::DEPTH),
                  out_valid_r && out_status_r == spq_pkg::ST_FULL &&
                  count_r == CNT_W'(spq_pkg::DEPTH),
                  "missing full drop")

endmodule

### rtl/spq_store.sv
module spq_store (
  input  logic                       clk,
  input  spq_pkg::spq_wr_t           wr,
  input  logic [spq_pkg::PTR_W-1:0]  rd_addr,
  output spq_pkg::spq_entry_t        rd_entry
);

  spq_pkg::spq_entry_t mem [spq_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    rd_entry <= mem[rd_addr];
  end

endmodule
